[rtl/mmf_pkg.sv]
// Shared types and constants of the MIDI message framer.
`default_nettype none

package mmf_pkg;

   // Longest variable-length count, in count bytes.
   localparam int unsigned MAX_LENGTH_BYTES = 4;
   // Width of the decoded count and of the payload byte counter.
   localparam int unsigned LEN_W            = 28;
   // Width of the count byte counter.
   localparam int unsigned LCNT_W           = 3;

   // What a byte would open if it were taken as a status byte.
   typedef enum logic [1:0] {
      KIND_TWO_DATA,
      KIND_ONE_DATA,
      KIND_SYSTEM
   } kind_type;

   typedef enum logic [2:0] {
      ROLE_STATUS,
      ROLE_CHAN_DATA,
      ROLE_TYPE,
      ROLE_LENGTH,
      ROLE_PAYLOAD
   } role_type;

   typedef enum logic [1:0] {
      ERR_OK,
      ERR_NO_STATUS,
      ERR_BAD_LENGTH,
      ERR_TRUNCATED
   } err_type;

   // Classified input word, passed from the front end to the back end.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       buffer_end;
      logic       is_status;
      kind_type   kind;
   } req_word_type;

   // Result word, as it waits for the consumer.
   typedef struct packed {
      logic [7:0]       echo_byte;
      logic [7:0]       message_status;
      role_type         byte_role;
      logic             first_of_message;
      logic             last_of_message;
      logic [LEN_W-1:0] payload_length;
      err_type          error_code;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/mmf_front.sv]
// Front end: input register stage that classifies each incoming byte.
`default_nettype none

module mmf_front import mmf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   stream_byte,
   input  wire logic         buffer_end,
   output logic              word_valid,
   output req_word_type      word,
   input  wire logic         queue_full
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   req_word_type word_in;
   logic         accept;
   logic         handoff;

   // The stage can take a byte when it is empty or its word moves on this cycle.
   assign handoff = valid_ff && !queue_full;
   assign full    = valid_ff && queue_full;
   assign accept  = push && !full;

   always_comb begin
      word_in.stream_byte = stream_byte;
      word_in.buffer_end  = buffer_end;
      word_in.is_status   = stream_byte[7];
      case (stream_byte[7:4])
         4'hC, 4'hD: word_in.kind = KIND_ONE_DATA;
         4'hF:       word_in.kind = KIND_SYSTEM;
         default:    word_in.kind = KIND_TWO_DATA;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (handoff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

[rtl/mmf_queue.sv]
// Two-entry queue of classified words between the front end and the back end.
`default_nettype none

module mmf_queue import mmf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire req_word_type push_word,
   output logic              full,
   input  wire logic         pop,
   output logic              valid,
   output req_word_type      head
);

   req_word_type slot_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         do_push;
   logic         do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

[rtl/mmf_back.sv]
// Back end: framing state machine and the two-entry result buffer.
`default_nettype none

module mmf_back import mmf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         running_status_enable,
   input  wire logic         word_valid,
   input  wire req_word_type word,
   output logic              word_pop,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output rsp_word_type      rsp_word
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CHAN,
      PH_TYPE,
      PH_LEN,
      PH_PAY
   } phase_type;

   phase_type         phase_ff;
   phase_type         phase_in;
   phase_type         body_phase;
   logic [7:0]        rs_ff;
   logic [7:0]        rs_in;
   kind_type          rs_kind_ff;
   kind_type          rs_kind_in;
   logic [7:0]        cur_ff;
   logic [7:0]        cur_in;
   logic [LEN_W-1:0]  rem_ff;
   logic [LEN_W-1:0]  rem_in;
   logic [LEN_W-1:0]  acc_ff;
   logic [LEN_W-1:0]  acc_in;
   logic [LCNT_W-1:0] cnt_ff;
   logic [LCNT_W-1:0] cnt_in;
   logic              do_open;
   logic              do_body;
   kind_type          open_kind;
   rsp_word_type      res;

   rsp_word_type      slot_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              out_full;
   logic              consume;
   logic              do_pop;

   assign out_full  = (count_ff == 2'd2);
   assign consume   = word_valid && !out_full;
   assign word_pop  = consume;
   assign rsp_empty = (count_ff == 2'd0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      phase_in   = phase_ff;
      rs_in      = rs_ff;
      rs_kind_in = rs_kind_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      do_open    = 1'b0;
      do_body    = 1'b0;
      open_kind  = word.kind;
      body_phase = PH_IDLE;

      res.echo_byte        = word.stream_byte;
      res.message_status   = 8'h00;
      res.byte_role        = ROLE_STATUS;
      res.first_of_message = 1'b0;
      res.last_of_message  = 1'b0;
      res.payload_length   = '0;
      res.error_code       = ERR_OK;

      // Between messages: a status byte opens one, a data byte may reuse
      // the running status.
      if (phase_ff == PH_IDLE) begin
         if (word.is_status) begin
            rs_in      = word.stream_byte;
            rs_kind_in = word.kind;
            cur_in     = word.stream_byte;
            do_open    = 1'b1;
         end else if (running_status_enable && rs_ff[7]) begin
            cur_in    = rs_ff;
            open_kind = rs_kind_ff;
            do_open   = 1'b1;
            do_body   = 1'b1;
         end else begin
            res.error_code = ERR_NO_STATUS;
         end
      end else begin
         do_body = 1'b1;
      end

      if (do_open) begin
         res.first_of_message = 1'b1;
         acc_in = '0;
         cnt_in = '0;
         case (open_kind)
            KIND_SYSTEM: begin
               phase_in = PH_TYPE;
               rem_in   = '0;
            end
            KIND_ONE_DATA: begin
               phase_in = PH_CHAN;
               rem_in   = LEN_W'(1);
            end
            default: begin
               phase_in = PH_CHAN;
               rem_in   = LEN_W'(2);
            end
         endcase
      end

      if (do_body) begin
         body_phase = phase_in;
         case (body_phase)
            PH_CHAN: begin
               res.byte_role = ROLE_CHAN_DATA;
               if (rem_in <= LEN_W'(1)) begin
                  res.last_of_message = 1'b1;
                  phase_in = PH_IDLE;
                  rem_in   = '0;
               end else begin
                  rem_in = rem_in - LEN_W'(1);
               end
            end
            PH_TYPE: begin
               res.byte_role = ROLE_TYPE;
               phase_in = PH_LEN;
               acc_in   = '0;
               cnt_in   = '0;
            end
            PH_LEN: begin
               res.byte_role = ROLE_LENGTH;
               acc_in = {acc_in[LEN_W-8:0], word.stream_byte[6:0]};
               cnt_in = cnt_in + LCNT_W'(1);
               if (word.stream_byte[7]) begin
                  if (cnt_in >= LCNT_W'(MAX_LENGTH_BYTES)) begin
                     res.error_code = ERR_BAD_LENGTH;
                     phase_in = PH_IDLE;
                     rem_in   = '0;
                  end
               end else begin
                  res.payload_length = acc_in;
                  if (acc_in == '0) begin
                     res.last_of_message = 1'b1;
                     phase_in = PH_IDLE;
                     rem_in   = '0;
                  end else begin
                     phase_in = PH_PAY;
                     rem_in   = acc_in;
                  end
               end
            end
            PH_PAY: begin
               res.byte_role      = ROLE_PAYLOAD;
               res.payload_length = acc_in;
               if (rem_in <= LEN_W'(1)) begin
                  res.last_of_message = 1'b1;
                  phase_in = PH_IDLE;
                  rem_in   = '0;
               end else begin
                  rem_in = rem_in - LEN_W'(1);
               end
            end
            default: begin
               phase_in = PH_IDLE;
               rem_in   = '0;
            end
         endcase
      end

      if (res.error_code != ERR_NO_STATUS) begin
         res.message_status = cur_in;
      end

      // A buffer that ends inside a message cuts it short.
      if (res.error_code == ERR_OK && word.buffer_end && !res.last_of_message) begin
         res.error_code = ERR_TRUNCATED;
         phase_in = PH_IDLE;
         rem_in   = '0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (consume && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !consume) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         rs_ff      <= 8'h00;
         rs_kind_ff <= KIND_TWO_DATA;
         cur_ff     <= 8'h00;
         rem_ff     <= '0;
         acc_ff     <= '0;
         cnt_ff     <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (consume) begin
            phase_ff   <= phase_in;
            rs_ff      <= rs_in;
            rs_kind_ff <= rs_kind_in;
            cur_ff     <= cur_in;
            rem_ff     <= rem_in;
            acc_ff     <= acc_in;
            cnt_ff     <= cnt_in;
            wr_ptr_ff  <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

`ifndef NO_ASSERTIONS
   // A word that closes a message or fails leaves the framer between messages.
   a_idle_after_close: assert property (@(posedge clock) disable iff (reset)
      consume && (res.last_of_message || res.error_code != ERR_OK)
      |=> phase_ff == PH_IDLE)
      else $error("framer not idle after a closing or failing word");

   // Only a word taken between messages can open a message.
   a_first_from_idle: assert property (@(posedge clock) disable iff (reset)
      consume && res.first_of_message |-> phase_ff == PH_IDLE)
      else $error("message opened while another was in progress");

   // A payload byte is only framed while bytes of the payload remain.
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      consume && phase_ff == PH_PAY |-> rem_ff != '0 && acc_ff != '0)
      else $error("payload byte framed with no payload left");

   // The result buffer never holds more than two words.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
`endif

endmodule

`default_nettype wire

[rtl/midi_message_framer.sv]
// Top level of the MIDI message framer: front end, word queue and back end.
//
//  channel   direction  handshake                     words
//  req_      in         push / full                   one stream byte and its end-of-buffer flag
//  rsp_      out        empty / pop                   one framed byte with role, status and flags
//  csr_      in         valid / ready                 running status enable, one bit
//
// The framing state machine takes a waiting byte whenever the result buffer has room, and a
// byte can be accepted on every clock while req_full is low; an accepted byte passes through
// the input register, the word queue and the result buffer before it can be popped.
// Reset is synchronous and active high; it empties every stage, leaves the framer between
// messages with no running status, and clears the enable.
// The input side stalls (full high) only when the front register and the two-entry word queue
// are all occupied, which happens only once the consumer has held off pop.
// The configuration port is always ready; it should be written only while the block is idle.
`default_nettype none

module midi_message_framer import mmf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_stream_byte,
   input  wire logic              req_buffer_end,

   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [7:0]             rsp_echo_byte,
   output logic [7:0]             rsp_message_status,
   output logic [2:0]             rsp_byte_role,
   output logic                   rsp_first_of_message,
   output logic                   rsp_last_of_message,
   output logic [LEN_W-1:0]       rsp_payload_length,
   output logic [1:0]             rsp_error_code,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_running_status_enable
);

   // Configuration register: running status enable.
   logic         rs_enable_ff;

   // Front end to word queue.
   logic         front_valid;
   req_word_type front_word;
   logic         queue_full;

   // Word queue to back end.
   logic         queue_valid;
   req_word_type queue_head;
   logic         queue_pop;

   rsp_word_type rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         rs_enable_ff <= csr_running_status_enable;
      end
   end

   // The front end registers each byte and works out what it would open as a status byte.
   mmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .stream_byte (req_stream_byte),
      .buffer_end  (req_buffer_end),
      .word_valid  (front_valid),
      .word        (front_word),
      .queue_full  (queue_full)
   );

   // A short queue lets the front end keep taking bytes while the back end waits.
   mmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_word (front_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .head      (queue_head)
   );

   // The back end runs the framing state machine and buffers the results.
   mmf_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .running_status_enable (rs_enable_ff),
      .word_valid            (queue_valid),
      .word                  (queue_head),
      .word_pop              (queue_pop),
      .rsp_pop               (rsp_pop),
      .rsp_empty             (rsp_empty),
      .rsp_word              (rsp_word)
   );

   assign rsp_echo_byte        = rsp_word.echo_byte;
   assign rsp_message_status   = rsp_word.message_status;
   assign rsp_byte_role        = rsp_word.byte_role;
   assign rsp_first_of_message = rsp_word.first_of_message;
   assign rsp_last_of_message  = rsp_word.last_of_message;
   assign rsp_payload_length   = rsp_word.payload_length;
   assign rsp_error_code       = rsp_word.error_code;

endmodule

`default_nettype wire
